@@ sv/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
package tcw_pkg;

	localparam int POS_W  = 11;
	localparam int CELL_W = 16;

	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_COLOR = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	localparam logic [7:0]        CHAR_NEWLINE = 8'd10;
	localparam logic [3:0]        CLEAR_INK    = 4'hF;
	localparam logic [CELL_W-1:0] CLEAR_WORD   = 16'h0F20;
	localparam logic [CELL_W-1:0] BLANK_RESET  = 16'h000F;

	// Completion report from the sequencer to the output stage.
	typedef struct packed {
		logic             done;
		logic             use_rd;
		logic [POS_W-1:0] pos;
	} tcw_result_t;

endpackage

@@ sv/tcw_cell_ram.sv @@
// Character-cell store: one write port, one read port with registered read data.
module tcw_cell_ram #(
	parameter int DEPTH  = 2000,
	parameter int ADDR_W = 11
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [ADDR_W-1:0]          waddr,
	input  logic [tcw_pkg::CELL_W-1:0] wdata,
	input  logic [ADDR_W-1:0]          raddr,
	output logic [tcw_pkg::CELL_W-1:0] rdata
);

	logic [tcw_pkg::CELL_W-1:0] mem_q [DEPTH];
	logic [tcw_pkg::CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sv/tcw_seq.sv @@
// Request sequencer: cursor tracking, scroll copy and fill sweeps over the cell store.
module tcw_seq #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25,
	parameter int NCELLS  = 2000,
	parameter int ADDR_W  = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_acc,
	input  logic [1:0]                 req_type,
	input  logic [7:0]                 char_code,
	input  logic [3:0]                 color_value,
	input  logic [10:0]                cell_index,
	input  logic [tcw_pkg::CELL_W-1:0] blank_fill,
	input  logic [tcw_pkg::CELL_W-1:0] rd_data,
	output logic                       busy,
	output logic                       mem_we,
	output logic [ADDR_W-1:0]          mem_waddr,
	output logic [tcw_pkg::CELL_W-1:0] mem_wdata,
	output logic [ADDR_W-1:0]          mem_raddr,
	output tcw_pkg::tcw_result_t       res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_COPY = 2'd1;
	localparam logic [1:0] ST_FILL = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(NCELLS - 1);
	localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
	localparam logic [ADDR_W-1:0] COL_STEP      = ADDR_W'(COLUMNS);

	logic [1:0]                 state_q;
	logic [6:0]                 col_q;
	logic [4:0]                 row_q;
	logic [ADDR_W-1:0]          lin_q;
	logic [3:0]                 color_q;
	logic [ADDR_W-1:0]          cnt_q;
	logic [tcw_pkg::CELL_W-1:0] fill_q;
	logic                       use_rd_q;
	logic                       cp_vld_s1;
	logic [ADDR_W-1:0]          cp_dst_s1;

	logic              is_nl;
	logic              wrap;
	logic              row_adv;
	logic              scroll;
	logic [ADDR_W:0]   nl_lin;
	logic [ADDR_W-1:0] put_lin;
	logic [31:0]       idx_ext;
	logic              idx_ok;
	logic [31:0]       pos_ext;
	logic              cnt_last;

	assign is_nl   = (char_code == tcw_pkg::CHAR_NEWLINE);
	assign wrap    = (col_q == 7'(COLUMNS - 1));
	assign row_adv = is_nl || wrap;
	assign scroll  = row_adv && (row_q == 5'(ROWS - 1));
	// A newline lands on the start of the next row: offset minus column plus one row.
	assign nl_lin  = (ADDR_W+1)'(lin_q) - (ADDR_W+1)'(col_q) + (ADDR_W+1)'(COLUMNS);
	assign put_lin = is_nl ? nl_lin[ADDR_W-1:0] : ADDR_W'(lin_q + 1'b1);
	assign idx_ext = 32'(cell_index);
	assign idx_ok  = (idx_ext < 32'(NCELLS));
	assign pos_ext = 32'(lin_q);
	assign cnt_last = (cnt_q == LAST_CELL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			col_q     <= '0;
			row_q     <= '0;
			lin_q     <= '0;
			color_q   <= '0;
			cnt_q     <= '0;
			fill_q    <= '0;
			use_rd_q  <= 1'b0;
			cp_vld_s1 <= 1'b0;
			cp_dst_s1 <= '0;
		end else begin
			cp_vld_s1 <= (state_q == ST_COPY);
			cp_dst_s1 <= ADDR_W'(cnt_q - COL_STEP);
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						use_rd_q <= (req_type == tcw_pkg::REQ_READ) && idx_ok;
						state_q  <= ST_FIN;
						case (req_type)
							tcw_pkg::REQ_PUT: begin
								if (scroll) begin
									row_q   <= 5'(ROWS - 1);
									col_q   <= '0;
									lin_q   <= LAST_ROW_BASE;
									cnt_q   <= COL_STEP;
									fill_q  <= blank_fill;
									state_q <= ST_COPY;
								end else begin
									col_q <= row_adv ? 7'd0 : 7'(col_q + 1'b1);
									row_q <= row_adv ? 5'(row_q + 1'b1) : row_q;
									lin_q <= put_lin;
								end
							end
							tcw_pkg::REQ_COLOR: begin
								color_q <= color_value;
							end
							tcw_pkg::REQ_CLEAR: begin
								color_q <= tcw_pkg::CLEAR_INK;
								col_q   <= '0;
								row_q   <= '0;
								lin_q   <= '0;
								cnt_q   <= '0;
								fill_q  <= tcw_pkg::CLEAR_WORD;
								state_q <= ST_FILL;
							end
							default: begin
							end
						endcase
					end
				end
				ST_COPY: begin
					if (cnt_last) begin
						cnt_q   <= LAST_ROW_BASE;
						state_q <= ST_FILL;
					end else begin
						cnt_q <= ADDR_W'(cnt_q + 1'b1);
					end
				end
				ST_FILL: begin
					// The last copy write still owns the write port on the first fill cycle.
					if (!cp_vld_s1) begin
						if (cnt_last) begin
							state_q <= ST_FIN;
						end else begin
							cnt_q <= ADDR_W'(cnt_q + 1'b1);
						end
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = lin_q;
		mem_wdata = {4'd0, color_q, char_code};
		if (cp_vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = cp_dst_s1;
			mem_wdata = rd_data;
		end else if (state_q == ST_FILL) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_q;
			mem_wdata = fill_q;
		end else if (in_acc && (req_type == tcw_pkg::REQ_PUT) && !is_nl) begin
			mem_we = 1'b1;
		end
	end

	assign mem_raddr  = (state_q == ST_COPY) ? cnt_q : idx_ext[ADDR_W-1:0];
	assign busy       = (state_q != ST_IDLE);
	assign res.done   = (state_q == ST_FIN);
	assign res.use_rd = use_rd_q;
	assign res.pos    = pos_ext[tcw_pkg::POS_W-1:0];

	a_copy_from_copy: assert property (@(posedge clk) disable iff (!arst_n)
		cp_vld_s1 |-> $past(state_q) == ST_COPY)
		else $error("copy write without a preceding copy read");

	a_fin_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> (state_q == ST_IDLE))
		else $error("finish state did not return to idle");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (state_q == ST_IDLE))
		else $error("item accepted while the sequencer was busy");

endmodule

@@ sv/text_console_writer_core.sv @@
// Top level of the text console writer: config register, sequencer, cell store, output stage.
// Put, set color and read each go from accept through the finish state into the output register.
// A put that scrolls runs a copy sweep, a turnaround for the last copy write, then the bottom-row fill.
// A clear fills every cell one at a time through the single write port of the cell store.
// Reset clears the cursor, color, output valid and sets blank_fill to 0x000F.
// The cell store is not cleared by reset; its contents are undefined until the first clear.
module text_console_writer_core #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // char_code[7:0], color_value[11:8], cell_index[22:12]
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // cursor_pos[10:0], cell_data[26:11]
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	localparam int NCELLS = ROWS * COLUMNS;
	localparam int ADDR_W = $clog2(NCELLS);

	logic [tcw_pkg::CELL_W-1:0] blank_fill_q;
	logic                       m_tvalid_q;
	logic [tcw_pkg::POS_W-1:0]  pos_q;
	logic [tcw_pkg::CELL_W-1:0] data_q;

	logic                       in_acc;
	logic                       busy;
	logic                       mem_we;
	logic [ADDR_W-1:0]          mem_waddr;
	logic [tcw_pkg::CELL_W-1:0] mem_wdata;
	logic [ADDR_W-1:0]          mem_raddr;
	logic [tcw_pkg::CELL_W-1:0] rd_data;
	tcw_pkg::tcw_result_t       res;

	assign s_tready = !busy && (!m_tvalid_q || m_tready);
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_fill_q <= tcw_pkg::BLANK_RESET;
		end else if (cfg_wr_en) begin
			blank_fill_q <= cfg_wr_data;
		end
	end

	tcw_seq #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.NCELLS  (NCELLS),
		.ADDR_W  (ADDR_W)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_acc      (in_acc),
		.req_type    (s_tuser),
		.char_code   (s_tdata[7:0]),
		.color_value (s_tdata[11:8]),
		.cell_index  (s_tdata[22:12]),
		.blank_fill  (blank_fill_q),
		.rd_data     (rd_data),
		.busy        (busy),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.res         (res)
	);

	tcw_cell_ram #(
		.DEPTH  (NCELLS),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			pos_q      <= '0;
			data_q     <= '0;
		end else if (res.done) begin
			m_tvalid_q <= 1'b1;
			pos_q      <= res.pos;
			data_q     <= res.use_rd ? rd_data : '0;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, data_q, pos_q};

	a_done_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> !m_tvalid_q)
		else $error("result finished while the output register was still full");

endmodule

@@ tb/tcw_checker.sv @@
`timescale 1ns / 1ps
// Checker for the text console writer: predicts every result and compares it with the block's.
module tcw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[7:0], color_value[11:8], cell_index[22:12]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // cursor_pos[10:0], cell_data[26:11]
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	output int          mismatches,
	output int          pending,
	output int          results_seen
);

	localparam int NCELLS = ROWS * COLUMNS;

	typedef struct packed {
		logic [tcw_pkg::POS_W-1:0]  pos;
		logic [tcw_pkg::CELL_W-1:0] word;
	} console_result_t;

	logic [tcw_pkg::CELL_W-1:0] screen [NCELLS];
	int                         row;
	int                         col;
	logic [3:0]                 ink;
	logic [tcw_pkg::CELL_W-1:0] blank_word;
	console_result_t            expected_q [$];
	console_result_t            want;
	int                         n_reported;

	task automatic report_mismatch(string what, int unsigned got, int unsigned wanted);
		if (n_reported < 40) begin
			$display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, wanted);
		end
		n_reported++;
		mismatches++;
	endtask

	function automatic void scroll_screen();
		for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
			screen[i] = screen[i + COLUMNS];
		end
		for (int i = (ROWS - 1) * COLUMNS; i < NCELLS; i++) begin
			screen[i] = blank_word;
		end
		row = ROWS - 1;
	endfunction

	// Advances the console state by one request and returns the result it produces.
	function automatic console_result_t apply_request(logic [1:0] req, logic [7:0] ch,
			logic [3:0] new_color, logic [10:0] idx);
		console_result_t r;
		r.word = '0;
		case (req)
			tcw_pkg::REQ_PUT: begin
				if (ch == tcw_pkg::CHAR_NEWLINE) begin
					col = 0;
					row++;
				end else begin
					screen[row * COLUMNS + col] = {4'h0, ink, ch};
					col++;
				end
				if (col >= COLUMNS) begin
					col = 0;
					row++;
				end
				if (row >= ROWS) scroll_screen();
			end
			tcw_pkg::REQ_COLOR: ink = new_color;
			tcw_pkg::REQ_CLEAR: begin
				ink = tcw_pkg::CLEAR_INK;
				foreach (screen[i]) screen[i] = tcw_pkg::CLEAR_WORD;
				row = 0;
				col = 0;
			end
			tcw_pkg::REQ_READ: begin
				if (idx < NCELLS) r.word = screen[idx];
			end
			default: ;
		endcase
		r.pos = tcw_pkg::POS_W'(row * COLUMNS + col);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row = 0;
			col = 0;
			ink = '0;
			blank_word = tcw_pkg::BLANK_RESET;
			expected_q.delete();
			mismatches = 0;
			n_reported = 0;
			pending <= 0;
			results_seen <= 0;
		end else begin
			// The result side goes first: a result never belongs to an item accepted at the same edge.
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with nothing expected", m_tdata, 0);
				end else begin
					want = expected_q.pop_front();
					if (m_tdata[10:0] !== want.pos) begin
						report_mismatch("cursor_pos", 32'(m_tdata[10:0]), 32'(want.pos));
					end
					if (m_tdata[26:11] !== want.word) begin
						report_mismatch("cell_data", 32'(m_tdata[26:11]), 32'(want.word));
					end
				end
				results_seen <= results_seen + 1;
			end
			if (s_tvalid && s_tready) begin
				expected_q.push_back(apply_request(s_tuser, s_tdata[7:0], s_tdata[11:8],
					s_tdata[22:12]));
			end
			if (cfg_wr_en) blank_word = cfg_wr_data;
			pending <= expected_q.size();
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the text console writer: clock, reset, stimulus and verdict.
module tb;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int NCELLS     = ROWS * COLUMNS;
	localparam int BOTTOM_ROW = (ROWS - 1) * COLUMNS;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // char_code[7:0], color_value[11:8], cell_index[22:12]
	logic [1:0]  s_tuser;   // req_type[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // cursor_pos[10:0], cell_data[26:11]
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	int mismatches;
	int pending;
	int results_seen;
	int n_sent;
	bit calm;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	text_console_writer_core #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	tcw_checker #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.mismatches  (mismatches),
		.pending     (pending),
		.results_seen(results_seen)
	);

	// Mostly short gaps, now and then a long one.
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 80) return $urandom_range(1, 3);
		if (pick < 96) return $urandom_range(4, 15);
		return $urandom_range(30, 120);
	endfunction

	// Offers one item; arg fills the field that the request uses, the others are random.
	task automatic send_request(logic [1:0] req, int unsigned arg);
		logic [7:0]  ch;
		logic [3:0]  new_color;
		logic [10:0] idx;
		ch = 8'($urandom);
		new_color = 4'($urandom);
		idx = 11'($urandom);
		case (req)
			tcw_pkg::REQ_PUT:   ch = 8'(arg);
			tcw_pkg::REQ_COLOR: new_color = 4'(arg);
			tcw_pkg::REQ_READ:  idx = 11'(arg);
			default: ;
		endcase
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {1'b0, idx, new_color, ch};
		// Inputs only move at rising edges, so tready at the falling edge holds for the next one.
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		n_sent++;
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat (idle_len()) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_phase(int count);
		int stop;
		int pick;
		int len;
		stop = n_sent + count;
		while (n_sent < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				// A line of text, sometimes long enough to wrap.
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 100) : $urandom_range(0, 30);
				repeat (len) send_request(tcw_pkg::REQ_PUT, $urandom_range(0, 255));
				if ($urandom_range(0, 1) == 0) begin
					send_request(tcw_pkg::REQ_PUT, 32'(tcw_pkg::CHAR_NEWLINE));
				end
			end else if (pick < 55) begin
				send_request(tcw_pkg::REQ_COLOR, $urandom_range(0, 15));
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 4)) begin
					pick = $urandom_range(0, 99);
					if (pick < 40) begin
						send_request(tcw_pkg::REQ_READ, $urandom_range(BOTTOM_ROW, NCELLS - 1));
					end else if (pick < 55) begin
						send_request(tcw_pkg::REQ_READ, $urandom_range(0, COLUMNS - 1));
					end else begin
						send_request(tcw_pkg::REQ_READ, $urandom_range(0, 2047));
					end
				end
			end else if (pick < 83) begin
				repeat ($urandom_range(1, 6)) begin
					send_request(tcw_pkg::REQ_PUT, 32'(tcw_pkg::CHAR_NEWLINE));
				end
			end else if (pick < 84) begin
				send_request(tcw_pkg::REQ_CLEAR, 0);
			end else begin
				pick = $urandom_range(0, 2);
				send_request((pick == 0) ? tcw_pkg::REQ_PUT :
					(pick == 1) ? tcw_pkg::REQ_COLOR : tcw_pkg::REQ_READ,
					$urandom_range(0, 2047));
			end
		end
	endtask

	initial begin : receiver
		int holds;
		holds = 0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (holds < 2 && results_seen >= ((holds == 0) ? 150 : 1000)) begin
				// Long hold-off so that the block backs up and stalls its input.
				m_tready <= 1'b0;
				repeat (600) @(posedge clk);
				holds++;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat (idle_len()) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : stimulus
		logic [15:0] fill;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		calm = 1'b0;
		n_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Before the first clear the store holds nothing defined, so no reads yet.
		send_request(tcw_pkg::REQ_PUT, 'h41);
		send_request(tcw_pkg::REQ_COLOR, 'hF);
		send_request(tcw_pkg::REQ_PUT, 'hFF);
		send_request(tcw_pkg::REQ_PUT, 32'(tcw_pkg::CHAR_NEWLINE));
		send_request(tcw_pkg::REQ_CLEAR, 0);
		send_request(tcw_pkg::REQ_READ, 0);
		send_request(tcw_pkg::REQ_READ, NCELLS - 1);
		send_request(tcw_pkg::REQ_READ, NCELLS);
		send_request(tcw_pkg::REQ_READ, 2047);
		send_request(tcw_pkg::REQ_COLOR, 0);
		send_request(tcw_pkg::REQ_PUT, 0);
		send_request(tcw_pkg::REQ_COLOR, 'hA);
		send_request(tcw_pkg::REQ_PUT, 'h7E);
		send_request(tcw_pkg::REQ_PUT, 32'(tcw_pkg::CHAR_NEWLINE));
		send_request(tcw_pkg::REQ_PUT, 32'(tcw_pkg::CHAR_NEWLINE));
		send_request(tcw_pkg::REQ_PUT, 'h20);
		send_request(tcw_pkg::REQ_READ, 0);
		send_request(tcw_pkg::REQ_READ, 1);
		send_request(tcw_pkg::REQ_READ, 2 * COLUMNS);
		drain();

		// The first phase scrolls with the reset fill word, the others with written ones.
		for (int p = 0; p < 5; p++) begin
			if (p > 0) begin
				fill = (p == 1) ? 16'h0000 : (p == 2) ? 16'hFFFF :
					(p == 4) ? tcw_pkg::CLEAR_WORD : 16'($urandom);
				cfg_wr_en <= 1'b1;
				cfg_wr_data <= fill;
				@(posedge clk);
				cfg_wr_en <= 1'b0;
			end
			calm = (p == 2);
			random_phase(390);
			if (p < 4) drain();
		end

		s_tvalid <= 1'b0;
		for (int w = 0; w < 10000 && pending != 0; w++) @(negedge clk);
		repeat (20) @(posedge clk);
		if (pending != 0) $display("%0d results never arrived", pending);
		if (mismatches == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin : watchdog
		#300_000_000;
		$display("timeout with %0d results outstanding", pending);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
